// ===== hdl/fmos_pkg.sv =====
// fmos_pkg: types, codes and helpers of the flight-mode ownership supervisor
// used by the configuration registers, the decision stage and the top level
// no dependencies
package fmos_pkg;

  // number of landing phase codes that can be marked in a phase mask
  localparam int PhaseCodes = 16;

  localparam int HeightW = 19;
  localparam int ReqW    = 20;
  localparam int MaskW   = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 19;

  localparam logic [HeightW-1:0] DefaultHeightRst = 19'd1500;

  // landing phases with a fixed meaning
  localparam logic [3:0] PhaseReady    = 4'd0;
  localparam logic [3:0] PhaseHoldWait = 4'd1;

  typedef enum logic [1:0] {
    OWN_IDLE  = 2'd0,
    OWN_TRACK = 2'd1,
    OWN_LAND  = 2'd2,
    OWN_HOLD  = 2'd3
  } owner_e;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_TRACK    = 3'd1,
    CMD_LAND     = 3'd2,
    CMD_HOLD     = 3'd3,
    CMD_POSITION = 3'd4,
    CMD_STOP     = 3'd5,
    CMD_UNSUP    = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    PLAN_NONE     = 3'd0,
    PLAN_MANUAL   = 3'd1,
    PLAN_SAFETY   = 3'd2,
    PLAN_RECOVERY = 3'd3,
    PLAN_PASSIVE  = 3'd4
  } plan_kind_e;

  typedef enum logic [4:0] {
    RSN_NONE              = 5'd0,
    RSN_FUSION_NOT_READY  = 5'd1,
    RSN_TRACK_REQ         = 5'd2,
    RSN_TRACK_SAME        = 5'd3,
    RSN_TRACK_RESTART     = 5'd4,
    RSN_LAND_STALE        = 5'd5,
    RSN_LAND_COMMITTED    = 5'd6,
    RSN_TRACK_PREEMPT_OFF = 5'd7,
    RSN_LAND_BY_TRACK     = 5'd8,
    RSN_LAND_REQ          = 5'd9,
    RSN_LAND_PREEMPT_OFF  = 5'd10,
    RSN_TRACK_BY_LAND     = 5'd11,
    RSN_LAND_ALREADY      = 5'd12,
    RSN_HOLD_REQ          = 5'd13,
    RSN_POS_REQ           = 5'd14,
    RSN_TRACK_BY_POS      = 5'd15,
    RSN_LAND_BY_POS       = 5'd16,
    RSN_STOP_REQ          = 5'd17,
    RSN_UNSUPPORTED       = 5'd18,
    RSN_FUSION_DEGRADED   = 5'd19,
    RSN_RECOVER_TRACK     = 5'd20,
    RSN_LAND_INACTIVE     = 5'd21
  } reason_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEFAULT_HEIGHT  = 3'd0,
    CFG_TRACK_PREEMPT   = 3'd1,
    CFG_LAND_PREEMPT    = 3'd2,
    CFG_AUTO_HOLD       = 3'd3,
    CFG_AUTO_RECOVER    = 3'd4,
    CFG_COMMIT_MASK     = 3'd5,
    CFG_RECOVER_MASK    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                   fusion_fresh;
    logic                   fusion_diag_seen;
    logic                   fusion_initialized;
    logic                   fusion_reloc_request;
    logic                   landing_fresh;
    logic                   landing_active;
    logic                   landing_state_seen;
    logic [3:0]             landing_phase;
    logic [2:0]             command;
    logic signed [ReqW-1:0] requested_height_mm;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         plan_kind;
    logic               accepted;
    logic [4:0]         reason_code;
    logic               track_start;
    logic               track_stop;
    logic               start_landing;
    logic               stop_landing;
    logic               hold_req;
    logic               request_position;
    logic [HeightW-1:0] tracking_height_out_mm;
    logic [1:0]         owner_now;
  } out_item_t;

  // configuration seen by the decision stage
  typedef struct packed {
    logic [HeightW-1:0] default_height_mm;
    logic               allow_track_preempt_landing;
    logic               allow_landing_preempt_track;
    logic               auto_hold_on_degrade;
    logic               auto_recover_on_loss;
    logic [MaskW-1:0]   commit_phase_mask;
    logic [MaskW-1:0]   recover_phase_mask;
  } cfg_t;

  // phase membership; codes past the table are in no set
  function automatic logic phase_in(logic [3:0] phase, logic [MaskW-1:0] mask);
    logic hit;
    hit = 1'b0;
    if (int'(phase) < PhaseCodes && int'(phase) < MaskW) begin
      hit = mask[phase];
    end
    return hit;
  endfunction

endpackage

// ===== hdl/flight_mode_ownership_supervisor_core.sv =====
// a request is taken into the input stage register and its result into the result register
// throughput: one request per cycle unless the output stalls; the decision and the owner
//   state update are one combinational pass between the input stage and result registers
// reset: asynchronous, active low; owner idle, tracking height 1500 mm, recovery and capture
//   flags cleared, configuration registers back to their defaults, both stages empty
// depends on fmos_pkg, fmos_cfg_regs, fmos_decide
module flight_mode_ownership_supervisor_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fmos_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fmos_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fmos_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fmos_pkg::CfgDataW-1:0] cfg_data_i
);
  import fmos_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_item_q;
  logic      s1_valid_q, s1_valid_d;
  out_item_t out_item_q;
  out_item_t result;
  logic      out_valid_q, out_valid_d;
  logic      s1_adv;
  logic      in_fire;
  logic      dec_fire;

  fmos_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // pipeline flow control
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign dec_fire   = s1_valid_q && s1_adv;

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_adv);
  assign out_valid_d = dec_fire || (out_valid_q && out_stall_i);

  // input stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
  end

  fmos_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (dec_fire),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // an accepted tracking start leaves tracking as owner
  a_track_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.accepted && out_item_q.track_start |->
      out_item_q.owner_now == OWN_TRACK)
    else $error("tracking start without tracking owner");

  // an accepted landing start leaves landing as owner
  a_land_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.accepted && out_item_q.start_landing |->
      out_item_q.owner_now == OWN_LAND)
    else $error("landing start without landing owner");

  // a rejected manual plan starts nothing
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.plan_kind == PLAN_MANUAL && !out_item_q.accepted |->
      !out_item_q.track_start && !out_item_q.start_landing)
    else $error("rejected plan carries a start flag");

  // no plan means nothing accepted and no reason
  a_no_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.plan_kind == PLAN_NONE |->
      !out_item_q.accepted && out_item_q.reason_code == RSN_NONE)
    else $error("empty plan with accept or reason");

  // the input side stalls only behind a held stage
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with free pipeline");
`endif

endmodule

// ===== hdl/fmos_cfg_regs.sv =====
// fmos_cfg_regs: configuration register file of the ownership supervisor
// depends on fmos_pkg
module fmos_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fmos_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fmos_pkg::CfgDataW-1:0] cfg_data_i,
  output fmos_pkg::cfg_t                cfg_o
);
  import fmos_pkg::*;

  cfg_t cfg_q, cfg_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register write decode, unknown indexes dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEFAULT_HEIGHT: cfg_d.default_height_mm = cfg_data_i[HeightW-1:0];
        CFG_TRACK_PREEMPT:  cfg_d.allow_track_preempt_landing = cfg_data_i[0];
        CFG_LAND_PREEMPT:   cfg_d.allow_landing_preempt_track = cfg_data_i[0];
        CFG_AUTO_HOLD:      cfg_d.auto_hold_on_degrade = cfg_data_i[0];
        CFG_AUTO_RECOVER:   cfg_d.auto_recover_on_loss = cfg_data_i[0];
        CFG_COMMIT_MASK:    cfg_d.commit_phase_mask = cfg_data_i[MaskW-1:0];
        CFG_RECOVER_MASK:   cfg_d.recover_phase_mask = cfg_data_i[MaskW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_height_mm           <= DefaultHeightRst;
      cfg_q.allow_track_preempt_landing <= 1'b1;
      cfg_q.allow_landing_preempt_track <= 1'b1;
      cfg_q.auto_hold_on_degrade        <= 1'b1;
      cfg_q.auto_recover_on_loss        <= 1'b1;
      cfg_q.commit_phase_mask           <= '0;
      cfg_q.recover_phase_mask          <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/fmos_decide.sv =====
// fmos_decide: ownership state and the plan decision for one request
// depends on fmos_pkg
module fmos_decide (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  fmos_pkg::in_item_t  item_i,
  input  fmos_pkg::cfg_t      cfg_i,
  output fmos_pkg::out_item_t result_o
);
  import fmos_pkg::*;

  owner_e             own_q, own_d;
  logic [HeightW-1:0] active_h_q, active_h_d;
  logic               recov_ok_q, recov_ok_d;
  logic [HeightW-1:0] recov_h_q, recov_h_d;
  logic               capture_q, capture_d;

  logic               f_ready;
  logic               capture_now;
  logic               committed;
  logic [HeightW-1:0] req_height;
  logic [HeightW-1:0] rec_height;
  logic [HeightW-1:0] height_diff;

  plan_kind_e         kind;
  logic               acc;
  reason_e            reason;
  logic               st_t, sp_t, st_l, sp_l, hold, pos;
  logic [HeightW-1:0] height;
  owner_e             after;

  // status qualifiers
  assign f_ready = item_i.fusion_fresh && item_i.fusion_diag_seen &&
                   item_i.fusion_initialized && !item_i.fusion_reloc_request;
  assign committed = item_i.landing_fresh && item_i.landing_active &&
                     phase_in(item_i.landing_phase, cfg_i.commit_phase_mask);

  // capture flag as refreshed by this status
  always_comb begin
    capture_now = capture_q;
    if (item_i.landing_fresh && item_i.landing_active && item_i.landing_state_seen &&
        item_i.landing_phase != PhaseReady && item_i.landing_phase != PhaseHoldWait) begin
      capture_now = 1'b1;
    end
    if (!item_i.landing_active && own_q != OWN_LAND) begin
      capture_now = 1'b0;
    end
  end

  // height resolution, zero or negative falls back to the default
  assign req_height = (item_i.requested_height_mm[ReqW-1] ||
                       item_i.requested_height_mm == '0) ?
                      cfg_i.default_height_mm : item_i.requested_height_mm[HeightW-1:0];
  assign rec_height = (recov_h_q == '0) ? cfg_i.default_height_mm : recov_h_q;
  assign height_diff = (active_h_q > req_height) ? (active_h_q - req_height)
                                                 : (req_height - active_h_q);

  // plan builder
  always_comb begin
    kind   = PLAN_NONE;
    acc    = 1'b0;
    reason = RSN_NONE;
    st_t   = 1'b0;
    sp_t   = 1'b0;
    st_l   = 1'b0;
    sp_l   = 1'b0;
    hold   = 1'b0;
    pos    = 1'b0;
    height = '0;
    after  = OWN_IDLE;
    if (item_i.command != CMD_NONE) begin
      kind = PLAN_MANUAL;
      acc  = 1'b1;
      unique case (item_i.command)
        CMD_TRACK: begin
          if (!f_ready) begin
            acc    = 1'b0;
            reason = RSN_FUSION_NOT_READY;
          end else begin
            height = req_height;
            st_t   = 1'b1;
            after  = OWN_TRACK;
            reason = RSN_TRACK_REQ;
            if (own_q == OWN_TRACK) begin
              if (height_diff <= 19'd1) begin
                st_t   = 1'b0;
                reason = RSN_TRACK_SAME;
              end else begin
                sp_t   = 1'b1;
                reason = RSN_TRACK_RESTART;
              end
            end else if (own_q == OWN_LAND) begin
              priority if (!item_i.landing_fresh) begin
                acc = 1'b0; st_t = 1'b0; reason = RSN_LAND_STALE;
              end else if (committed) begin
                acc = 1'b0; st_t = 1'b0; reason = RSN_LAND_COMMITTED;
              end else if (!cfg_i.allow_track_preempt_landing) begin
                acc = 1'b0; st_t = 1'b0; reason = RSN_TRACK_PREEMPT_OFF;
              end else begin
                sp_l = 1'b1; reason = RSN_LAND_BY_TRACK;
              end
            end
          end
        end
        CMD_LAND: begin
          st_l   = 1'b1;
          after  = OWN_LAND;
          reason = RSN_LAND_REQ;
          if (own_q == OWN_TRACK) begin
            if (!cfg_i.allow_landing_preempt_track) begin
              acc = 1'b0; st_l = 1'b0; reason = RSN_LAND_PREEMPT_OFF;
            end else begin
              sp_t = 1'b1; reason = RSN_TRACK_BY_LAND;
            end
          end else if (own_q == OWN_LAND) begin
            st_l = 1'b0; reason = RSN_LAND_ALREADY;
          end
        end
        CMD_HOLD, CMD_STOP: begin
          sp_t   = (own_q == OWN_TRACK);
          sp_l   = (own_q == OWN_LAND);
          hold   = 1'b1;
          after  = (item_i.command == CMD_HOLD) ? OWN_HOLD : OWN_IDLE;
          reason = (item_i.command == CMD_HOLD) ? RSN_HOLD_REQ : RSN_STOP_REQ;
        end
        CMD_POSITION: begin
          pos    = 1'b1;
          after  = OWN_IDLE;
          reason = RSN_POS_REQ;
          if (own_q == OWN_TRACK) begin
            sp_t = 1'b1; reason = RSN_TRACK_BY_POS;
          end else if (own_q == OWN_LAND) begin
            priority if (!item_i.landing_fresh) begin
              acc = 1'b0; pos = 1'b0; reason = RSN_LAND_STALE;
            end else if (committed) begin
              acc = 1'b0; pos = 1'b0; reason = RSN_LAND_COMMITTED;
            end else begin
              sp_l = 1'b1; reason = RSN_LAND_BY_POS;
            end
          end
        end
        default: begin
          acc    = 1'b0;
          reason = RSN_UNSUPPORTED;
        end
      endcase
    end else if (cfg_i.auto_hold_on_degrade && !f_ready &&
                 (own_q == OWN_TRACK || own_q == OWN_LAND)) begin
      kind   = PLAN_SAFETY;
      acc    = 1'b1;
      reason = RSN_FUSION_DEGRADED;
      sp_t   = (own_q == OWN_TRACK);
      sp_l   = (own_q == OWN_LAND);
      hold   = 1'b1;
      after  = OWN_HOLD;
    end else if (own_q == OWN_LAND && cfg_i.auto_recover_on_loss && recov_ok_q && f_ready &&
                 item_i.landing_fresh && capture_now && !committed &&
                 item_i.landing_active &&
                 phase_in(item_i.landing_phase, cfg_i.recover_phase_mask)) begin
      kind   = PLAN_RECOVERY;
      acc    = 1'b1;
      reason = RSN_RECOVER_TRACK;
      sp_l   = 1'b1;
      st_t   = 1'b1;
      height = rec_height;
      after  = OWN_TRACK;
    end else if (own_q == OWN_LAND && item_i.landing_fresh && item_i.landing_state_seen &&
                 !item_i.landing_active && item_i.landing_phase == PhaseReady) begin
      kind   = PLAN_PASSIVE;
      acc    = 1'b1;
      reason = RSN_LAND_INACTIVE;
      after  = OWN_IDLE;
    end
  end

  // apply an accepted plan
  always_comb begin
    own_d      = own_q;
    active_h_d = active_h_q;
    recov_ok_d = recov_ok_q;
    recov_h_d  = recov_h_q;
    capture_d  = capture_now;
    if (acc) begin
      own_d = after;
      if (st_t) begin
        active_h_d = height;
      end
      if (st_l) begin
        if (own_q == OWN_TRACK) begin
          recov_ok_d = 1'b1;
          recov_h_d  = active_h_q;
        end else begin
          recov_ok_d = 1'b0;
          recov_h_d  = '0;
        end
      end else if (own_q == OWN_LAND && after != OWN_LAND) begin
        recov_ok_d = 1'b0;
        recov_h_d  = '0;
      end
      if (st_l || after != OWN_LAND) begin
        capture_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q      <= OWN_IDLE;
      active_h_q <= DefaultHeightRst;
      recov_ok_q <= 1'b0;
      recov_h_q  <= '0;
      capture_q  <= 1'b0;
    end else if (fire_i) begin
      own_q      <= own_d;
      active_h_q <= active_h_d;
      recov_ok_q <= recov_ok_d;
      recov_h_q  <= recov_h_d;
      capture_q  <= capture_d;
    end
  end

  // result fields
  always_comb begin
    result_o.plan_kind              = kind;
    result_o.accepted               = acc;
    result_o.reason_code            = reason;
    result_o.track_start            = st_t;
    result_o.track_stop             = sp_t;
    result_o.start_landing          = st_l;
    result_o.stop_landing           = sp_l;
    result_o.hold_req               = hold;
    result_o.request_position       = pos;
    result_o.tracking_height_out_mm = height;
    result_o.owner_now              = own_d;
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for flight_mode_ownership_supervisor_core, a scoreboard class
// predicts each plan from the request stream while plain tasks drive and stall the ports
// depends on fmos_pkg and the core
module tb;
  import fmos_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int RandomPerPhase = 292;
  localparam int RandomPhases = 6;
  localparam int IdlePct = 22;
  // index past the register file, writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 3'd7;
  // command code past the defined set
  localparam logic [2:0] CmdReserved = 3'd7;

  // plan predictor and result checker
  class ownership_scoreboard;
    logic [HeightW-1:0] default_height;
    bit                 track_preempt_ok;
    bit                 land_preempt_ok;
    bit                 hold_on_degrade;
    bit                 recover_on_loss;
    logic [MaskW-1:0]   commit_mask;
    logic [MaskW-1:0]   recover_mask;
    owner_e             owner;
    logic [HeightW-1:0] active_height;
    bit                 recovery_ok;
    logic [HeightW-1:0] recovery_height;
    bit                 capture_seen;
    out_item_t          plans_due[$];
    int                 errors;

    function new();
      default_height   = DefaultHeightRst;
      track_preempt_ok = 1'b1;
      land_preempt_ok  = 1'b1;
      hold_on_degrade  = 1'b1;
      recover_on_loss  = 1'b1;
      commit_mask      = '0;
      recover_mask     = '0;
      owner            = OWN_IDLE;
      active_height    = DefaultHeightRst;
      recovery_ok      = 1'b0;
      recovery_height  = '0;
      capture_seen     = 1'b0;
      errors           = 0;
    endfunction

    function void apply_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_DEFAULT_HEIGHT: default_height   = data[HeightW-1:0];
        CFG_TRACK_PREEMPT:  track_preempt_ok = data[0];
        CFG_LAND_PREEMPT:   land_preempt_ok  = data[0];
        CFG_AUTO_HOLD:      hold_on_degrade  = data[0];
        CFG_AUTO_RECOVER:   recover_on_loss  = data[0];
        CFG_COMMIT_MASK:    commit_mask      = data[MaskW-1:0];
        CFG_RECOVER_MASK:   recover_mask     = data[MaskW-1:0];
        default: ;
      endcase
    endfunction

    function bit in_phase_set(logic [3:0] phase, logic [MaskW-1:0] mask);
      return (int'(phase) < PhaseCodes) && mask[phase];
    endfunction

    // non-positive heights fall back to the default register
    function logic [HeightW-1:0] resolve_height(int req);
      logic [31:0] raw;
      raw = req;
      if (req <= 0) return default_height;
      return raw[HeightW-1:0];
    endfunction

    function out_item_t decide_plan(in_item_t it);
      bit                 f_ready;
      bit                 committed;
      bit                 lf;
      bit                 la;
      bit                 ls;
      owner_e             own;
      owner_e             after;
      logic [HeightW-1:0] gap;
      out_item_t          p;
      f_ready = it.fusion_fresh && it.fusion_diag_seen && it.fusion_initialized &&
                !it.fusion_reloc_request;
      lf = it.landing_fresh;
      la = it.landing_active;
      ls = it.landing_state_seen;
      own = owner;
      after = OWN_IDLE;
      p = '0;

      // capture tracking from the landing report
      if (lf && la && ls && it.landing_phase != PhaseReady && it.landing_phase != PhaseHoldWait)
        capture_seen = 1'b1;
      if (!la && own != OWN_LAND) capture_seen = 1'b0;
      committed = lf && la && in_phase_set(it.landing_phase, commit_mask);

      if (it.command != CMD_NONE) begin
        // manual plan
        p.plan_kind = PLAN_MANUAL;
        p.accepted = 1'b1;
        case (it.command)
          CMD_TRACK: begin
            if (!f_ready) begin
              p.accepted = 1'b0;
              p.reason_code = RSN_FUSION_NOT_READY;
            end else begin
              p.tracking_height_out_mm = resolve_height($signed(it.requested_height_mm));
              p.track_start = 1'b1;
              after = OWN_TRACK;
              p.reason_code = RSN_TRACK_REQ;
              if (own == OWN_TRACK) begin
                gap = (active_height > p.tracking_height_out_mm) ?
                      active_height - p.tracking_height_out_mm :
                      p.tracking_height_out_mm - active_height;
                if (gap <= 1) begin
                  p.track_start = 1'b0;
                  p.reason_code = RSN_TRACK_SAME;
                end else begin
                  p.track_stop = 1'b1;
                  p.reason_code = RSN_TRACK_RESTART;
                end
              end else if (own == OWN_LAND) begin
                if (!lf) begin
                  p.accepted = 1'b0;
                  p.track_start = 1'b0;
                  p.reason_code = RSN_LAND_STALE;
                end else if (committed) begin
                  p.accepted = 1'b0;
                  p.track_start = 1'b0;
                  p.reason_code = RSN_LAND_COMMITTED;
                end else if (!track_preempt_ok) begin
                  p.accepted = 1'b0;
                  p.track_start = 1'b0;
                  p.reason_code = RSN_TRACK_PREEMPT_OFF;
                end else begin
                  p.stop_landing = 1'b1;
                  p.reason_code = RSN_LAND_BY_TRACK;
                end
              end
            end
          end
          CMD_LAND: begin
            p.start_landing = 1'b1;
            after = OWN_LAND;
            p.reason_code = RSN_LAND_REQ;
            if (own == OWN_TRACK) begin
              if (!land_preempt_ok) begin
                p.accepted = 1'b0;
                p.start_landing = 1'b0;
                p.reason_code = RSN_LAND_PREEMPT_OFF;
              end else begin
                p.track_stop = 1'b1;
                p.reason_code = RSN_TRACK_BY_LAND;
              end
            end else if (own == OWN_LAND) begin
              p.start_landing = 1'b0;
              p.reason_code = RSN_LAND_ALREADY;
            end
          end
          CMD_HOLD, CMD_STOP: begin
            p.track_stop = (own == OWN_TRACK);
            p.stop_landing = (own == OWN_LAND);
            p.hold_req = 1'b1;
            after = (it.command == CMD_HOLD) ? OWN_HOLD : OWN_IDLE;
            p.reason_code = (it.command == CMD_HOLD) ? RSN_HOLD_REQ : RSN_STOP_REQ;
          end
          CMD_POSITION: begin
            p.request_position = 1'b1;
            after = OWN_IDLE;
            p.reason_code = RSN_POS_REQ;
            if (own == OWN_TRACK) begin
              p.track_stop = 1'b1;
              p.reason_code = RSN_TRACK_BY_POS;
            end else if (own == OWN_LAND) begin
              if (!lf) begin
                p.accepted = 1'b0;
                p.request_position = 1'b0;
                p.reason_code = RSN_LAND_STALE;
              end else if (committed) begin
                p.accepted = 1'b0;
                p.request_position = 1'b0;
                p.reason_code = RSN_LAND_COMMITTED;
              end else begin
                p.stop_landing = 1'b1;
                p.reason_code = RSN_LAND_BY_POS;
              end
            end
          end
          default: begin
            p.accepted = 1'b0;
            p.reason_code = RSN_UNSUPPORTED;
          end
        endcase
      end else if (hold_on_degrade && !f_ready && (own == OWN_TRACK || own == OWN_LAND)) begin
        // fusion degrade safety hold
        p.plan_kind = PLAN_SAFETY;
        p.accepted = 1'b1;
        p.reason_code = RSN_FUSION_DEGRADED;
        p.track_stop = (own == OWN_TRACK);
        p.stop_landing = (own == OWN_LAND);
        p.hold_req = 1'b1;
        after = OWN_HOLD;
      end else if (own == OWN_LAND && recover_on_loss && recovery_ok && f_ready && lf &&
                   capture_seen && !committed && la &&
                   in_phase_set(it.landing_phase, recover_mask)) begin
        // lost target before commit, back to tracking
        p.plan_kind = PLAN_RECOVERY;
        p.accepted = 1'b1;
        p.reason_code = RSN_RECOVER_TRACK;
        p.stop_landing = 1'b1;
        p.track_start = 1'b1;
        p.tracking_height_out_mm = resolve_height(int'(recovery_height));
        after = OWN_TRACK;
      end else if (own == OWN_LAND && lf && ls && !la && it.landing_phase == PhaseReady) begin
        // landing finished on its own
        p.plan_kind = PLAN_PASSIVE;
        p.accepted = 1'b1;
        p.reason_code = RSN_LAND_INACTIVE;
        after = OWN_IDLE;
      end

      // apply accepted plan
      if (p.accepted) begin
        owner = after;
        if (p.track_start) active_height = p.tracking_height_out_mm;
        if (p.start_landing) begin
          if (own == OWN_TRACK) begin
            recovery_ok = 1'b1;
            recovery_height = active_height;
          end else begin
            recovery_ok = 1'b0;
            recovery_height = '0;
          end
        end else if (own == OWN_LAND && owner != OWN_LAND) begin
          recovery_ok = 1'b0;
          recovery_height = '0;
        end
        if (p.start_landing || owner != OWN_LAND) capture_seen = 1'b0;
      end
      p.owner_now = owner;
      return p;
    endfunction

    function void note_request(in_item_t it);
      plans_due.push_back(decide_plan(it));
    endfunction

    function int pending();
      return plans_due.size();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (plans_due.size() == 0) begin
        $error("plan result with no request outstanding");
        errors++;
        return;
      end
      want = plans_due.pop_front();
      compare_field("plan_kind", want.plan_kind, got.plan_kind);
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("reason_code", want.reason_code, got.reason_code);
      compare_field("track_start", want.track_start, got.track_start);
      compare_field("track_stop", want.track_stop, got.track_stop);
      compare_field("start_landing", want.start_landing, got.start_landing);
      compare_field("stop_landing", want.stop_landing, got.stop_landing);
      compare_field("hold_req", want.hold_req, got.hold_req);
      compare_field("request_position", want.request_position, got.request_position);
      compare_field("tracking_height_out_mm", want.tracking_height_out_mm,
                    got.tracking_height_out_mm);
      compare_field("owner_now", want.owner_now, got.owner_now);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_item_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ownership_scoreboard sb = new();
  bit                  calm = 1'b0;
  int                  sent_count = 0;
  int unsigned         cycle_count = 0;

  flight_mode_ownership_supervisor_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycle counter and watchdog
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAILED: results differ");
    $finish;
  end

  // random result backpressure, none while calm
  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < IdlePct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  // send one request, with random idle cycles ahead of it
  task automatic send_request(input in_item_t it);
    if (!calm) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(it);
    sent_count++;
  endtask

  // one register write; valid is left high for back-to-back writes
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.apply_register(idx, data);
  endtask

  // one-bit flag with random upper data bits
  function automatic logic [CfgDataW-1:0] flag_word(bit f);
    logic [CfgDataW-1:0] w;
    w = CfgDataW'($urandom);
    w[0] = f;
    return w;
  endfunction

  function automatic logic [CfgDataW-1:0] mask_word(logic [MaskW-1:0] m);
    logic [CfgDataW-1:0] w;
    w = CfgDataW'($urandom);
    w[MaskW-1:0] = m;
    return w;
  endfunction

  // drain outstanding plans, then rewrite every register
  task automatic program_settings(input int sel);
    logic [CfgDataW-1:0] h;
    logic [3:0]          flags;
    logic [MaskW-1:0]    commit;
    logic [MaskW-1:0]    recov;
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    h = CfgDataW'($urandom_range(524287, 1));
    flags = 4'($urandom);
    commit = MaskW'($urandom);
    recov = MaskW'($urandom);
    case (sel)
      0: begin
        h = DefaultHeightRst;
        flags = 4'hf;
        commit = 16'h0020;
        recov = 16'h0018;
      end
      1: flags = 4'hf;
      2: begin
        h = '0;
        flags = 4'h0;
        commit = 16'hffff;
        recov = 16'hffff;
      end
      3: begin
        h = 19'h7ffff;
        commit = '0;
      end
      4: begin
        h = 19'd1;
        flags = 4'hf;
        commit = '0;
        recov = 16'hffff;
      end
      5: h = CfgDataW'($urandom);
      default: h = DefaultHeightRst;
    endcase
    cfg_write(CFG_DEFAULT_HEIGHT, h);
    cfg_write(CFG_TRACK_PREEMPT, flag_word(flags[0]));
    cfg_write(CFG_LAND_PREEMPT, flag_word(flags[1]));
    cfg_write(CFG_AUTO_HOLD, flag_word(flags[2]));
    cfg_write(CFG_AUTO_RECOVER, flag_word(flags[3]));
    cfg_write(CFG_COMMIT_MASK, mask_word(commit));
    cfg_write(CFG_RECOVER_MASK, mask_word(recov));
    if (sel == 0) cfg_write(CfgUnusedIdx, CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // directed request; not ready means a relocalization request
  function automatic in_item_t make_item(bit ready, bit lf, bit la, bit ls, logic [3:0] ph,
                                         logic [2:0] cmd, int h);
    in_item_t it;
    it.fusion_fresh = 1'b1;
    it.fusion_diag_seen = 1'b1;
    it.fusion_initialized = 1'b1;
    it.fusion_reloc_request = !ready;
    it.landing_fresh = lf;
    it.landing_active = la;
    it.landing_state_seen = ls;
    it.landing_phase = ph;
    it.command = cmd;
    it.requested_height_mm = h[ReqW-1:0];
    return it;
  endfunction

  // heights around the extremes, the default and the current one
  function automatic logic signed [ReqW-1:0] pick_height();
    int h;
    case ($urandom_range(7))
      0: h = 0;
      1: h = -int'($urandom_range(524288, 1));
      2: h = int'(sb.active_height) + int'($urandom_range(4)) - 2;
      3: h = 524287;
      4: h = 1;
      5: h = int'($urandom_range(1502, 1498));
      default: h = int'($urandom_range(524287, 1));
    endcase
    return h[ReqW-1:0];
  endfunction

  // mostly healthy fusion and landing reports
  function automatic in_item_t status_item(logic [2:0] cmd);
    in_item_t it;
    it.fusion_fresh = $urandom_range(99) < 95;
    it.fusion_diag_seen = $urandom_range(99) < 97;
    it.fusion_initialized = $urandom_range(99) < 97;
    it.fusion_reloc_request = $urandom_range(99) < 4;
    it.landing_fresh = $urandom_range(99) < 90;
    it.landing_active = $urandom_range(99) < 85;
    it.landing_state_seen = $urandom_range(99) < 90;
    it.landing_phase = 4'($urandom_range(15));
    it.command = cmd;
    it.requested_height_mm = pick_height();
    return it;
  endfunction

  // maybe track, then land, a run of landing reports, maybe a clean landing end
  task automatic run_episode();
    int       steps;
    in_item_t it;
    if ($urandom_range(99) < 80) send_request(status_item(CMD_TRACK));
    send_request(status_item(CMD_LAND));
    steps = $urandom_range(8, 2);
    repeat (steps) begin
      if ($urandom_range(99) < 12) send_request(status_item(3'($urandom_range(7))));
      else send_request(status_item(CMD_NONE));
    end
    if ($urandom_range(1)) begin
      it = status_item(CMD_NONE);
      it.landing_fresh = 1'b1;
      it.landing_active = 1'b0;
      it.landing_state_seen = 1'b1;
      it.landing_phase = PhaseReady;
      send_request(it);
    end
  endtask

  // main sequence
  initial begin
    int          target;
    int          pick;
    logic [63:0] raw;
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk through owners, rejections and automatic plans
    program_settings(0);
    send_request(make_item(0, 1, 0, 1, 4'd0, CMD_TRACK, 2000));
    send_request(make_item(1, 1, 0, 1, 4'd0, CMD_TRACK, -524288));
    send_request(make_item(1, 1, 0, 1, 4'd0, CMD_TRACK, 1501));
    send_request(make_item(1, 1, 0, 1, 4'd0, CMD_TRACK, 524287));
    send_request(make_item(1, 1, 0, 1, 4'd0, CMD_TRACK, 1500));
    send_request(make_item(1, 1, 1, 1, 4'd2, CMD_LAND, 0));
    send_request(make_item(1, 1, 1, 1, 4'd6, CMD_NONE, 0));
    send_request(make_item(1, 1, 1, 1, 4'd3, CMD_NONE, 0));
    send_request(make_item(1, 1, 1, 1, 4'd2, CMD_LAND, 0));
    send_request(make_item(1, 0, 1, 1, 4'd2, CMD_TRACK, 900));
    send_request(make_item(1, 1, 1, 1, 4'd5, CMD_TRACK, 900));
    send_request(make_item(1, 1, 1, 1, 4'd5, CMD_POSITION, 0));
    send_request(make_item(1, 0, 1, 1, 4'd2, CMD_POSITION, 0));
    send_request(make_item(0, 1, 1, 1, 4'd2, CMD_NONE, 0));
    send_request(make_item(1, 1, 1, 1, 4'd2, CMD_LAND, 0));
    send_request(make_item(1, 1, 1, 1, 4'd2, CMD_LAND, 0));
    send_request(make_item(1, 1, 1, 1, 4'd2, CMD_POSITION, 0));
    send_request(make_item(1, 1, 1, 1, 4'd1, CMD_LAND, 0));
    send_request(make_item(1, 1, 0, 1, 4'd0, CMD_NONE, 0));
    send_request(make_item(1, 1, 0, 1, 4'd15, CMD_HOLD, 0));
    send_request(make_item(1, 1, 0, 1, 4'd0, CMD_STOP, 0));
    send_request(make_item(1, 1, 0, 1, 4'd0, CMD_POSITION, 0));
    send_request(make_item(1, 1, 0, 1, 4'd0, CMD_UNSUP, 0));
    send_request(make_item(1, 1, 0, 1, 4'd0, CmdReserved, 0));
    send_request(make_item(1, 1, 0, 1, 4'd0, CMD_TRACK, 0));
    send_request(make_item(1, 1, 0, 1, 4'd0, CMD_POSITION, 0));

    // random phases, each under its own settings; one runs with no idling
    for (int ph = 1; ph <= RandomPhases; ph++) begin
      program_settings(ph);
      calm = (ph == 3);
      target = sent_count + RandomPerPhase;
      while (sent_count < target) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          run_episode();
        end else if (pick < 85) begin
          send_request(status_item(3'($urandom_range(7))));
        end else begin
          raw = {$urandom, $urandom};
          send_request(raw[$bits(in_item_t)-1:0]);
        end
      end
      calm = 1'b0;
    end
    in_valid_i <= 1'b0;

    // drain and settle
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
